// File: rtl/fvsc_pkg.sv
// Shared constants and types for the frustum vertex set cull unit.
package fvsc_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int NUM_PLANES  = 6;
	localparam int FIELD_W     = 16;
	localparam int PLANE_W     = 4 * FIELD_W;
	localparam int OFFSET_SH   = 14;
	localparam int PROD_W      = COORD_WIDTH + FIELD_W;
	localparam int OFFSET_W    = FIELD_W + OFFSET_SH;
	localparam int SUM_W       = ((PROD_W > OFFSET_W) ? PROD_W : OFFSET_W) + 2;
	localparam int IDX_W       = $clog2(NUM_PLANES);
	localparam int ADDR_W      = IDX_W + 3;
	localparam int DATA_W      = PLANE_W;

	typedef logic [PLANE_W-1:0] plane_t;
	typedef plane_t [NUM_PLANES-1:0] plane_set_t;

	// Vertex request as it travels along the row of plane cells
	typedef struct packed {
		logic                          last;
		logic                          culled;
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
	} tok_t;

endpackage

// File: rtl/fvsc_regs.sv
// APB register file holding the six packed frustum planes.
module fvsc_regs import fvsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output plane_set_t        planes
);

	plane_set_t      plane_q;
	logic [IDX_W-1:0] idx;
	logic             hit;

	assign idx = paddr[ADDR_W-1:3];
	assign hit = ({1'b0, idx} < (IDX_W+1)'(NUM_PLANES));

	// Write on the access phase; drop writes beyond the plane list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (psel && penable && pwrite && hit) begin
			plane_q[idx] <= pwdata;
		end
	end

	// Return the addressed plane, zero beyond the list
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = plane_q[idx];
		end
	end

	assign planes = plane_q;

endmodule

// File: rtl/fvsc_cell.sv
// One plane cell: two-stage signed distance test and the plane's all-outside flag.
module fvsc_cell import fvsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  plane_t plane,
	input  logic   in_valid,
	input  tok_t   in_tok,
	output logic   in_ready,
	output logic   out_valid,
	output tok_t   out_tok,
	input  logic   out_ready
);

	logic signed [FIELD_W-1:0] nx, ny, nz, d;
	logic signed [PROD_W-1:0]  px_s1, py_s1, pz_s1;
	tok_t                      tok_s1, tok_s2;
	tok_t                      tok_fold;
	logic                      v_s1, v_s2;
	logic                      flag_q;
	logic                      ready_s1, ready_s2;
	logic signed [SUM_W-1:0]   dist_sum;
	logic                      flag_now;

	assign nx = plane[FIELD_W-1:0];
	assign ny = plane[2*FIELD_W-1:FIELD_W];
	assign nz = plane[3*FIELD_W-1:2*FIELD_W];
	assign d  = plane[4*FIELD_W-1:3*FIELD_W];

	// Let each stage move when it is empty or its contents move on
	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Stage one: form the three products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			tok_s1 <= in_tok;
			px_s1  <= in_tok.x * nx;
			py_s1  <= in_tok.y * ny;
			pz_s1  <= in_tok.z * nz;
		end
	end

	// Sum the products and the scaled offset; negative means outside
	assign dist_sum = SUM_W'(px_s1) + SUM_W'(py_s1) + SUM_W'(pz_s1)
		+ (SUM_W'(d) <<< OFFSET_SH);
	assign flag_now = flag_q & dist_sum[SUM_W-1];

	// Stage two: fold the test into the flag, rearm it on the last vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			flag_q <= 1'b1;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				flag_q <= tok_s1.last ? 1'b1 : flag_now;
			end
		end
	end

	// Mark the request culled when this plane rejects the whole set
	always_comb begin
		tok_fold        = tok_s1;
		tok_fold.culled = tok_s1.culled | (tok_s1.last & flag_now);
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			tok_s2 <= tok_fold;
		end
	end

	assign out_valid = v_s2;
	assign out_tok   = tok_s2;

endmodule

// File: rtl/frustum_vertex_set_cull_unit.sv
// Top level of the frustum vertex set cull unit: register file, row of plane cells, result register.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  vertex   | vertex_valid / vertex_ready  | vertex_x, vertex_y, vertex_z, last_vertex
//  result   | result_valid / result_ready  | visible
//  config   | psel, penable, pwrite, pready| paddr, pwdata, prdata (64-bit planes at 8*i)
//
// One vertex is accepted every cycle while the row is not stalled; the row of six plane cells,
// two stages each, is followed by the result register, which takes the last vertex of a set.
// Each stage moves on its own, so bubbles close up and vertices keep entering while a
// result waits, until a last vertex reaches the end of the row. Reset clears all stage
// valids and the result, sets every plane flag and zeroes the planes; there is no clearing pass.
module frustum_vertex_set_cull_unit import fvsc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready,
	input  logic                          vertex_valid,
	output logic                          vertex_ready,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_z,
	input  logic                          last_vertex,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          visible
);

	plane_set_t                planes;
	logic [NUM_PLANES:0]       c_valid;
	logic [NUM_PLANES:0]       c_ready;
	tok_t [NUM_PLANES:0]       c_tok;
	logic                      result_valid_q;
	logic                      visible_q;
	logic                      tail_take;

	assign pready = 1'b1;

	fvsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.planes  (planes)
	);

	// Feed the request into the head of the row
	assign c_valid[0]        = vertex_valid;
	assign c_tok[0].last     = last_vertex;
	assign c_tok[0].culled   = 1'b0;
	assign c_tok[0].x        = vertex_x;
	assign c_tok[0].y        = vertex_y;
	assign c_tok[0].z        = vertex_z;
	assign vertex_ready      = c_ready[0];

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
		fvsc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.plane     (planes[i]),
			.in_valid  (c_valid[i]),
			.in_tok    (c_tok[i]),
			.in_ready  (c_ready[i]),
			.out_valid (c_valid[i+1]),
			.out_tok   (c_tok[i+1]),
			.out_ready (c_ready[i+1])
		);
	end

	// Drop vertices that end no set; hold a last vertex until the result slot frees
	assign c_ready[NUM_PLANES] = !c_tok[NUM_PLANES].last || !result_valid_q || result_ready;
	assign tail_take = c_valid[NUM_PLANES] && c_tok[NUM_PLANES].last && c_ready[NUM_PLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (tail_take) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_take) begin
			visible_q <= !c_tok[NUM_PLANES].culled;
		end
	end

	assign result_valid = result_valid_q;
	assign visible      = visible_q;

endmodule

// File: bench/fvsc_cull_checker.sv
// Checker for the frustum vertex set cull unit: watches the ports, predicts visibility, compares.
module fvsc_cull_checker import fvsc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	input  logic [DATA_W-1:0]             prdata,
	input  logic                          pready,
	input  logic                          vertex_valid,
	input  logic                          vertex_ready,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_z,
	input  logic                          last_vertex,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic                          visible,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	plane_set_t            plane_copy = '0;
	logic [NUM_PLANES-1:0] outside_acc = '1;
	logic                  visible_q[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Signed distance below zero puts the vertex outside the plane
	function automatic logic plane_rejects(plane_t p, logic signed [COORD_WIDTH-1:0] x,
			logic signed [COORD_WIDTH-1:0] y, logic signed [COORD_WIDTH-1:0] z);
		logic signed [FIELD_W-1:0] nx, ny, nz, d;
		longint sdist;
		nx = p[FIELD_W-1:0];
		ny = p[2*FIELD_W-1:FIELD_W];
		nz = p[3*FIELD_W-1:2*FIELD_W];
		d  = p[PLANE_W-1:3*FIELD_W];
		sdist = longint'(nx) * longint'(x) + longint'(ny) * longint'(y)
			+ longint'(nz) * longint'(z) + longint'(d) * longint'(1 << OFFSET_SH);
		return sdist < 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic                  want;
		logic [NUM_PLANES-1:0] hit;
		int                    idx;
		if (!arst_n) begin
			plane_copy = '0;
			outside_acc = '1;
			visible_q.delete();
			pending = 0;
		end else begin
			// Result request: compare with the oldest prediction
			if (result_valid && result_ready) begin
				if (visible_q.size() == 0) begin
					$error("visible: no result expected, actual %0b", visible);
					fail_count++;
				end else begin
					want = visible_q.pop_front();
					if (visible !== want) begin
						$error("visible: expected %0b, actual %0b", want, visible);
						fail_count++;
					end
				end
			end
			// Vertex request: narrow the all-outside flags, close the set on the last one
			if (vertex_valid && vertex_ready) begin
				for (int i = 0; i < NUM_PLANES; i++)
					hit[i] = plane_rejects(plane_copy[i], vertex_x, vertex_y, vertex_z);
				hit = outside_acc & hit;
				if (last_vertex) begin
					visible_q.push_back(hit == '0);
					outside_acc = '1;
				end else begin
					outside_acc = hit;
				end
			end
			// Register access: track writes, check read data of known planes
			if (psel && penable && pready) begin
				idx = int'(paddr >> 3);
				if (pwrite) begin
					if (idx < NUM_PLANES)
						plane_copy[idx] = pwdata;
				end else if (idx < NUM_PLANES && prdata !== plane_copy[idx]) begin
					$error("prdata: expected %h, actual %h", plane_copy[idx], prdata);
					fail_count++;
				end
			end
			pending = visible_q.size();
		end
	end

endmodule

// File: bench/tb_frustum_vertex_set_cull_unit.sv
// Testbench top for the frustum vertex set cull unit: clock, reset, stimulus and verdict.
module tb_frustum_vertex_set_cull_unit import fvsc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1450;
	localparam int PHASE_ITEMS = 180;
	localparam int SETTLE      = 20;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ADDR_W-1:0]             paddr;
	logic [DATA_W-1:0]             pwdata;
	logic [DATA_W-1:0]             prdata;
	logic                          pready;
	logic                          vertex_valid;
	logic                          vertex_ready;
	logic signed [COORD_WIDTH-1:0] vertex_x;
	logic signed [COORD_WIDTH-1:0] vertex_y;
	logic signed [COORD_WIDTH-1:0] vertex_z;
	logic                          last_vertex;
	logic                          result_valid;
	logic                          result_ready;
	logic                          visible;
	int                            fail_count;
	int                            pending;

	int item_count   = 0;
	int object_count = 0;
	int config_count = 0;
	bit tx_steady    = 0;
	bit rx_steady    = 0;

	frustum_vertex_set_cull_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.last_vertex  (last_vertex),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.visible      (visible)
	);

	fvsc_cull_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.last_vertex  (last_vertex),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.visible      (visible),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a request never completes
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic plane_t pack_plane(int nx, int ny, int nz, int d);
		return {FIELD_W'(d), FIELD_W'(nz), FIELD_W'(ny), FIELD_W'(nx)};
	endfunction

	// One register access: setup cycle, then access cycle until pready
	task automatic reg_access(input logic wr, input int idx, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'(idx * 8);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
	endtask

	// Load all six planes, poke an unmapped slot, read everything back
	task automatic load_planes(input plane_set_t cfg);
		for (int i = 0; i < NUM_PLANES; i++)
			reg_access(1'b1, i, cfg[i]);
		reg_access(1'b1, $urandom_range(NUM_PLANES, 7), {$urandom, $urandom});
		for (int i = 0; i < 8; i++)
			reg_access(1'b0, i, '0);
		psel    <= 1'b0;
		penable <= 1'b0;
		config_count++;
	endtask

	// Offer one vertex request, hold it until accepted
	task automatic push_vertex(input logic signed [COORD_WIDTH-1:0] x,
			input logic signed [COORD_WIDTH-1:0] y, input logic signed [COORD_WIDTH-1:0] z,
			input logic lst);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			vertex_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vertex_valid <= 1'b1;
		vertex_x     <= x;
		vertex_y     <= y;
		vertex_z     <= z;
		last_vertex  <= lst;
		@(negedge clk);
		while (!vertex_ready) @(negedge clk);
		@(posedge clk);
		item_count++;
		if (lst)
			object_count++;
	endtask

	// Drop valid, wait for every predicted result, then let the pipe settle
	task automatic drain();
		vertex_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic plane_t rand_plane(int style, int idx, int half);
		int unit;
		unit = (idx % 2) ? -(1 << OFFSET_SH) : (1 << OFFSET_SH);
		case (style)
			0: return {$urandom, $urandom};
			1: begin
				case (idx / 2)
					0: return pack_plane(0, 0, unit, half);
					1: return pack_plane(unit, 0, 0, half);
					default: return pack_plane(0, unit, 0, half);
				endcase
			end
			2: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return '1;
					2: return 64'h8000_8000_8000_8000;
					3: return 64'h7FFF_7FFF_7FFF_7FFF;
					default: return 64'h7FFF_8000_7FFF_8000;
				endcase
			end
			default: return pack_plane($urandom_range(0, 32768) - 16384,
				$urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
				$urandom_range(0, 65535) - 32768);
		endcase
	endfunction

	// One object: mostly a tight cluster of vertices, sometimes noise with stray last flags
	task automatic send_object(input int span);
		int n, spread;
		bit noisy;
		logic signed [COORD_WIDTH-1:0] cx, cy, cz;
		noisy  = ($urandom_range(0, 4) == 0);
		n      = $urandom_range(1, 8);
		spread = 1 << $urandom_range(0, 12);
		if ($urandom_range(0, 1)) begin
			cx = COORD_WIDTH'($urandom);
			cy = COORD_WIDTH'($urandom);
			cz = COORD_WIDTH'($urandom);
		end else begin
			cx = COORD_WIDTH'($urandom_range(0, 2 * span) - span);
			cy = COORD_WIDTH'($urandom_range(0, 2 * span) - span);
			cz = COORD_WIDTH'($urandom_range(0, 2 * span) - span);
		end
		for (int k = 0; k < n; k++) begin
			if (noisy)
				push_vertex(COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
					COORD_WIDTH'($urandom), (k == n - 1) ? 1'b1 : 1'($urandom));
			else
				push_vertex(COORD_WIDTH'(int'(cx) + $urandom_range(0, 2 * spread) - spread),
					COORD_WIDTH'(int'(cy) + $urandom_range(0, 2 * spread) - spread),
					COORD_WIDTH'(int'(cz) + $urandom_range(0, 2 * spread) - spread),
					k == n - 1);
		end
	endtask

	// Result side: random stalls per result, with stretches of none
	initial begin : result_sink
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(negedge clk);
			while (!result_valid) @(negedge clk);
			@(posedge clk);
		end
	end

	initial begin : stimulus
		plane_set_t cfg;
		int phase, mark, half;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		vertex_valid = 1'b0;
		vertex_x     = '0;
		vertex_y     = '0;
		vertex_z     = '0;
		last_vertex  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Planes at reset are all zero and never cull
		push_vertex(32767, 32767, 32767, 1'b1);
		push_vertex(-32768, -32768, -32768, 1'b1);
		push_vertex(0, 0, 0, 1'b0);
		push_vertex(-1, -1, -1, 1'b1);
		drain();

		// Axis-aligned box of half-size 100: inside, outside, on a face, straddling
		for (int i = 0; i < NUM_PLANES; i++)
			cfg[i] = rand_plane(1, i, 100);
		load_planes(cfg);
		push_vertex(0, 0, 0, 1'b1);
		push_vertex(200, 0, 0, 1'b1);
		push_vertex(-100, 0, 0, 1'b1);
		push_vertex(-101, 0, 0, 1'b1);
		push_vertex(0, 0, 100, 1'b1);
		push_vertex(200, 0, 0, 1'b0);
		push_vertex(-200, 0, 0, 1'b1);
		push_vertex(200, 0, 0, 1'b0);
		push_vertex(300, 5, 5, 1'b1);
		push_vertex(32767, -32768, 32767, 1'b1);
		push_vertex(-32768, 32767, -32768, 1'b1);
		drain();

		// Extreme plane fields, including a plane that rejects everything
		cfg[0] = pack_plane(-32768, 32767, -32768, -32768);
		cfg[1] = '1;
		cfg[2] = 64'h8000_8000_8000_8000;
		cfg[3] = 64'h7FFF_7FFF_7FFF_7FFF;
		cfg[4] = pack_plane(32767, 0, 0, 32767);
		cfg[5] = pack_plane(0, 0, 0, -32768);
		load_planes(cfg);
		push_vertex(32767, -32768, 32767, 1'b1);
		push_vertex(-32768, 32767, -32768, 1'b1);
		push_vertex(-32768, -32768, -32768, 1'b0);
		push_vertex(32767, 32767, 32767, 1'b1);
		drain();

		// Random phases, each under its own plane setting
		phase = 0;
		while (item_count < ITEM_TARGET) begin
			half = $urandom_range(0, 4000);
			for (int i = 0; i < NUM_PLANES; i++)
				cfg[i] = rand_plane(phase % 4, i, half);
			load_planes(cfg);
			mark = item_count;
			while (item_count - mark < PHASE_ITEMS && item_count < ITEM_TARGET)
				send_object(2 * half + 100);
			drain();
			phase++;
		end

		$display("Culled or passed %0d objects built from %0d vertex requests,", object_count,
			item_count);
		$display("under %0d plane settings with random gaps on both channels.", config_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
